@@ src/lss_pkg.sv @@
`timescale 1ns / 1ps
// shared types, codes and sizes of the rgb led step sequencer
// no dependencies

package lss_pkg;

  localparam int STEPS_DEFAULT = 16;
  localparam int TABLE_DEPTH   = 16;
  localparam int IDX_W         = $clog2(TABLE_DEPTH);
  localparam int POS_W         = $clog2(TABLE_DEPTH + 1);
  localparam int QUEUE_DEPTH   = 2;

  localparam int COLOR_W = 24;
  localparam int HOLD_W  = 16;
  localparam int REP_W   = 17;
  localparam int FUNC_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_START = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

  localparam logic KIND_SET  = 1'b0;
  localparam logic KIND_HOLD = 1'b1;

  typedef struct packed {
    logic               kind;
    logic [COLOR_W-1:0] color;
    logic [HOLD_W-1:0]  hold;
  } entry_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  op;
    logic [IDX_W-1:0]   index;
    entry_t             entry;
    logic [POS_W-1:0]   length;
    logic [REP_W-1:0]   repeats;
    logic [COLOR_W-1:0] final_color;
  } cmd_t;

endpackage

@@ src/lss_if.sv @@
`timescale 1ns / 1ps
// valid/ready channels of the rgb led step sequencer
// depends on lss_pkg

interface lss_req_if;
  logic                          valid;
  logic                          ready;
  logic [lss_pkg::FUNC_W-1:0]    func;
  logic [3:0]                    step_index;
  logic                          step_kind;
  logic [lss_pkg::COLOR_W-1:0]   step_color;
  logic [lss_pkg::HOLD_W-1:0]    step_hold_ms;
  logic [4:0]                    seq_length;
  logic signed [lss_pkg::REP_W-1:0] extra_repeats;
  logic [lss_pkg::COLOR_W-1:0]   final_color;

  modport source (
    output valid, func, step_index, step_kind, step_color, step_hold_ms,
           seq_length, extra_repeats, final_color,
    input  ready
  );
  modport sink (
    input  valid, func, step_index, step_kind, step_color, step_hold_ms,
           seq_length, extra_repeats, final_color,
    output ready
  );
endinterface

interface lss_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [lss_pkg::COLOR_W-1:0] led_color;
  logic                        finished;
  logic                        last;

  modport source (output valid, led_color, finished, last, input ready);
  modport sink   (input valid, led_color, finished, last, output ready);
endinterface

@@ src/lss_ram.sv @@
`timescale 1ns / 1ps
// generic single-write single-read ram with registered read data
// no dependencies

module lss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ src/lss_front.sv @@
`timescale 1ns / 1ps
// front end: accepts request transactions, drops unknown codes, packs commands
// depends on lss_pkg and lss_if

module lss_front (
  lss_req_if.sink          req,
  input  logic             q_full,
  output logic             q_push,
  output lss_pkg::cmd_t    q_data
);
  import lss_pkg::*;

  localparam logic [4:0] MAX_LEN = 5'(TABLE_DEPTH);

  logic [4:0] len_sat;

  assign req.ready = !q_full;
  assign q_push    = req.valid && !q_full && (req.func != FUNC_NONE);

  assign len_sat = (req.seq_length > MAX_LEN) ? MAX_LEN : req.seq_length;

  always_comb begin
    q_data.op          = req.func;
    q_data.index       = req.step_index[IDX_W-1:0];
    q_data.entry.kind  = req.step_kind;
    q_data.entry.color = req.step_color;
    q_data.entry.hold  = req.step_hold_ms;
    q_data.length      = POS_W'(len_sat);
    q_data.repeats     = req.extra_repeats;
    q_data.final_color = req.final_color;
  end

endmodule

@@ src/lss_queue.sv @@
`timescale 1ns / 1ps
// short command queue between front and back end
// depends on lss_pkg

module lss_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  lss_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output lss_pkg::cmd_t pop_data,
  output logic          not_empty
);
  import lss_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign pop_data  = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ src/lss_back.sv @@
`timescale 1ns / 1ps
// back end: step table, hold countdown, table walk and result register
// depends on lss_pkg, lss_if and lss_ram

module lss_back #(
  parameter int STEPS = lss_pkg::STEPS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  input  lss_pkg::cmd_t cmd,
  output logic          cmd_pop,
  lss_rsp_if.source     rsp
);
  import lss_pkg::*;

  localparam int VISIT_LIMIT = (STEPS < TABLE_DEPTH) ? STEPS : TABLE_DEPTH;
  localparam int VISIT_W     = $clog2(VISIT_LIMIT + 1);
  localparam logic [VISIT_W-1:0] VISIT_MAX = VISIT_W'(VISIT_LIMIT);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_EXEC  = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0]         state, state_next;
  logic               running, running_next;
  logic [POS_W-1:0]   active_length, active_length_next;
  logic [POS_W-1:0]   position, position_next;
  logic [REP_W-1:0]   repeats_left, repeats_left_next;
  logic [COLOR_W-1:0] end_color, end_color_next;
  logic [HOLD_W-1:0]  hold_left, hold_left_next;
  logic [VISIT_W-1:0] visits, visits_next;
  logic               pend_valid, pend_valid_next;
  logic [COLOR_W-1:0] pend_color, pend_color_next;
  logic               pend_fin, pend_fin_next;

  logic               out_valid;
  logic [COLOR_W-1:0] out_color;
  logic               out_fin;
  logic               out_last;

  logic               push_ok;
  logic               push_en;
  logic               push_last;

  logic               ram_we;
  logic               ram_re;
  entry_t             rd_entry;
  logic [POS_W-1:0]   pos_inc;

  lss_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.index),
    .wdata (cmd.entry),
    .re    (ram_re),
    .raddr (position[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  assign push_ok   = !out_valid || rsp.ready;
  assign pos_inc   = position + 1'b1;

  assign rsp.valid     = out_valid;
  assign rsp.led_color = out_color;
  assign rsp.finished  = out_fin;
  assign rsp.last      = out_last;

  always_comb begin
    state_next         = state;
    running_next       = running;
    active_length_next = active_length;
    position_next      = position;
    repeats_left_next  = repeats_left;
    end_color_next     = end_color;
    hold_left_next     = hold_left;
    visits_next        = visits;
    pend_valid_next    = pend_valid;
    pend_color_next    = pend_color;
    pend_fin_next      = pend_fin;
    cmd_pop            = 1'b0;
    ram_we             = 1'b0;
    ram_re             = 1'b0;
    push_en            = 1'b0;
    push_last          = 1'b0;

    case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          case (cmd.op)
            FUNC_TICK: begin
              if (running) begin
                if (hold_left <= HOLD_W'(1)) begin
                  hold_left_next = '0;
                  visits_next    = '0;
                  state_next     = S_CHECK;
                end else begin
                  hold_left_next = hold_left - 1'b1;
                end
              end
            end
            FUNC_WRITE: begin
              ram_we = 1'b1;
            end
            FUNC_START: begin
              active_length_next = cmd.length;
              repeats_left_next  = cmd.repeats[REP_W-1] ? '1 : cmd.repeats;
              end_color_next     = cmd.final_color;
              position_next      = '0;
              hold_left_next     = '0;
              visits_next        = '0;
              if (cmd.length == '0) begin
                running_next    = 1'b0;
                pend_valid_next = 1'b1;
                pend_color_next = cmd.final_color;
                pend_fin_next   = 1'b0;
                state_next      = S_FLUSH;
              end else begin
                running_next = 1'b1;
                state_next   = S_CHECK;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_CHECK: begin
        if (position >= active_length) begin
          if (!pend_valid || push_ok) begin
            push_en         = pend_valid;
            running_next    = 1'b0;
            hold_left_next  = '0;
            pend_valid_next = 1'b1;
            pend_color_next = end_color;
            pend_fin_next   = 1'b1;
            state_next      = S_FLUSH;
          end
        end else if (visits >= VISIT_MAX) begin
          hold_left_next = HOLD_W'(1);
          state_next     = S_FLUSH;
        end else begin
          ram_re     = 1'b1;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        if (rd_entry.kind == KIND_HOLD || !pend_valid || push_ok) begin
          if (rd_entry.kind == KIND_SET) begin
            push_en         = pend_valid;
            pend_valid_next = 1'b1;
            pend_color_next = rd_entry.color;
            pend_fin_next   = 1'b0;
          end
          visits_next = visits + 1'b1;
          if (pos_inc == active_length && repeats_left != '0) begin
            position_next = '0;
            if (!repeats_left[REP_W-1]) begin
              repeats_left_next = repeats_left - 1'b1;
            end
          end else begin
            position_next = pos_inc;
          end
          if (rd_entry.kind == KIND_HOLD && rd_entry.hold != '0) begin
            hold_left_next = rd_entry.hold;
            state_next     = S_FLUSH;
          end else begin
            state_next = S_CHECK;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (push_ok) begin
          push_en         = 1'b1;
          push_last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      running       <= 1'b0;
      active_length <= '0;
      position      <= '0;
      repeats_left  <= '0;
      end_color     <= '0;
      hold_left     <= '0;
      visits        <= '0;
      pend_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      running       <= running_next;
      active_length <= active_length_next;
      position      <= position_next;
      repeats_left  <= repeats_left_next;
      end_color     <= end_color_next;
      hold_left     <= hold_left_next;
      visits        <= visits_next;
      pend_valid    <= pend_valid_next;
      if (push_en) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_color <= pend_color_next;
    pend_fin   <= pend_fin_next;
    if (push_en) begin
      out_color <= pend_color;
      out_fin   <= pend_fin;
      out_last  <= push_last;
    end
  end

endmodule

@@ src/rgb_led_step_sequencer_top.sv @@
`timescale 1ns / 1ps
// rgb led step sequencer: req channel in, rsp channel out
// usage:
//   req carries one transaction per item: func 0 is a one-millisecond tick,
//   func 1 writes a step entry, func 2 starts a sequence, func 3 is dropped.
//   rsp carries the colors driven to the led; last marks the final result
//   of a request, finished marks the final color of a run that ended.
//   an item that causes no result produces no rsp transaction.
// flow:
//   requests are written into a two-entry command queue at the accepting
//   edge and are taken from it by the back end while it is idle.
//   a write or a tick without a walk is handled in the back end's idle state.
//   a walk visits each table entry by giving its address in the check state
//   and using the registered table read in the exec state; the last result
//   is then flushed to the output register.
// reset: rst (synchronous) clears the queue, stops any run, sets the end
//   color to zero; the step table holds unknown data until written.
// stall: a stalled rsp holds one result in the output register and one
//   pending; the walk waits, the queue fills and req.ready drops.
// depends on lss_pkg, lss_if, lss_front, lss_queue, lss_back

module rgb_led_step_sequencer_top #(
  parameter int STEPS = lss_pkg::STEPS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  lss_req_if.sink   req,
  lss_rsp_if.source rsp
);
  import lss_pkg::*;

  logic q_full;
  logic q_push;
  cmd_t q_in;
  logic q_pop;
  cmd_t q_out;
  logic q_not_empty;

  lss_front u_front (
    .req    (req),
    .q_full (q_full),
    .q_push (q_push),
    .q_data (q_in)
  );

  lss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .not_empty (q_not_empty)
  );

  lss_back #(
    .STEPS (STEPS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_not_empty),
    .cmd       (q_out),
    .cmd_pop   (q_pop),
    .rsp       (rsp)
  );

endmodule

@@ bench/rgb_led_step_sequencer_top_tb.sv @@
`timescale 1ns / 1ps
// self-checking bench for rgb_led_step_sequencer_top: directed and random step programs,
// with a color predictor in a small scoreboard class
// depends on lss_pkg, lss_if and the sequencer rtl

module rgb_led_step_sequencer_top_tb;
  import lss_pkg::*;

  localparam int VISIT_CAP  = (STEPS_DEFAULT < TABLE_DEPTH) ? STEPS_DEFAULT : TABLE_DEPTH;
  localparam int ITEMS      = 400;
  localparam int IDLE_LIMIT = 5000;
  localparam int LONG_HOLD  = 400;
  localparam int DRAIN_WAIT = 100;
  localparam logic signed [REP_W-1:0] REPEAT_FOREVER = -17'sd1;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic [3:0]                index;
    logic                      kind;
    logic [COLOR_W-1:0]        color;
    logic [HOLD_W-1:0]         hold;
    logic [4:0]                length;
    logic signed [REP_W-1:0]   repeats;
    logic [COLOR_W-1:0]        final_color;
  } led_cmd_t;

  typedef struct {
    logic [COLOR_W-1:0] color;
    logic               finished;
    logic               last;
  } led_result_t;

  class led_color_scoreboard;
    entry_t       steps[TABLE_DEPTH];
    int           length;
    int           pos;
    int           reps;
    logic [COLOR_W-1:0] end_color;
    int           hold_left;
    bit           running;
    led_result_t  pending_colors[$];
    int           errors;

    function new();
      length = 0;
      pos = 0;
      reps = 0;
      end_color = '0;
      hold_left = 0;
      running = 0;
      errors = 0;
    endfunction

    function void queue_color(logic [COLOR_W-1:0] color, logic finished);
      led_result_t r;
      r.color = color;
      r.finished = finished;
      r.last = 1'b0;
      pending_colors.push_back(r);
    endfunction

    function void walk_table();
      int visits;
      int delay;
      entry_t e;
      visits = 0;
      while (1'b1) begin
        if (pos >= length) begin
          running = 0;
          hold_left = 0;
          queue_color(end_color, 1'b1);
          return;
        end
        if (visits >= VISIT_CAP) begin
          hold_left = 1;
          return;
        end
        e = steps[pos % TABLE_DEPTH];
        visits++;
        delay = 0;
        if (e.kind == KIND_SET) begin
          queue_color(e.color, 1'b0);
        end else begin
          delay = e.hold;
        end
        pos++;
        if (pos == length && reps != 0) begin
          if (reps > 0) reps--;
          pos = 0;
        end
        if (delay != 0) begin
          hold_left = delay;
          return;
        end
      end
    endfunction

    function void predict_item(led_cmd_t c);
      int before_n;
      before_n = pending_colors.size();
      case (c.func)
        FUNC_TICK: begin
          if (running) begin
            if (hold_left > 0) hold_left--;
            if (hold_left == 0) walk_table();
          end
        end
        FUNC_WRITE: begin
          steps[c.index].kind = c.kind;
          steps[c.index].color = c.color;
          steps[c.index].hold = c.hold;
        end
        FUNC_START: begin
          length = (c.length > TABLE_DEPTH) ? TABLE_DEPTH : int'(c.length);
          reps = c.repeats[REP_W-1] ? -1 : int'(c.repeats[REP_W-2:0]);
          end_color = c.final_color;
          pos = 0;
          hold_left = 0;
          if (length == 0) begin
            running = 0;
            queue_color(end_color, 1'b0);
          end else begin
            running = 1;
            walk_table();
          end
        end
        default: ;
      endcase
      if (pending_colors.size() > before_n)
        pending_colors[pending_colors.size()-1].last = 1'b1;
    endfunction

    function int outstanding();
      return pending_colors.size();
    endfunction

    task report(string what);
      $display("[%0t] error: %s", $time, what);
      errors++;
    endtask

    task check_result(logic [COLOR_W-1:0] color, logic finished, logic last);
      led_result_t want;
      if (pending_colors.size() == 0) begin
        report($sformatf("unexpected result color %06h finished %b last %b",
                         color, finished, last));
      end else begin
        want = pending_colors.pop_front();
        if (color !== want.color)
          report($sformatf("led_color got %06h want %06h", color, want.color));
        if (finished !== want.finished)
          report($sformatf("finished got %b want %b (color %06h)", finished,
                           want.finished, want.color));
        if (last !== want.last)
          report($sformatf("last got %b want %b (color %06h)", last, want.last,
                           want.color));
      end
    endtask

    task final_check();
      if (pending_colors.size() != 0)
        report($sformatf("%0d results never arrived", pending_colors.size()));
    endtask
  endclass

  logic clk;
  logic rst;

  lss_req_if req();
  lss_rsp_if rsp();

  rgb_led_step_sequencer_top dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  led_color_scoreboard sb;
  led_cmd_t            seen_cmd;
  int                  req_burst;
  int                  rsp_burst;
  bit                  rsp_long_hold;
  int                  idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      burst = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic led_cmd_t noise_cmd(logic [FUNC_W-1:0] f);
    led_cmd_t c;
    c.func = f;
    c.index = 4'($urandom);
    c.kind = 1'($urandom);
    c.color = 24'($urandom);
    c.hold = 16'($urandom);
    c.length = 5'($urandom);
    c.repeats = 17'($urandom);
    c.final_color = 24'($urandom);
    return c;
  endfunction

  function automatic led_cmd_t write_cmd(logic [3:0] idx, logic kind, logic [COLOR_W-1:0] color,
                                         logic [HOLD_W-1:0] hold);
    led_cmd_t c;
    c = noise_cmd(FUNC_WRITE);
    c.index = idx;
    c.kind = kind;
    c.color = color;
    c.hold = hold;
    return c;
  endfunction

  function automatic led_cmd_t start_cmd(logic [4:0] len, logic signed [REP_W-1:0] reps,
                                         logic [COLOR_W-1:0] fin);
    led_cmd_t c;
    c = noise_cmd(FUNC_START);
    c.length = len;
    c.repeats = reps;
    c.final_color = fin;
    return c;
  endfunction

  function automatic led_cmd_t random_cmd();
    led_cmd_t c;
    int pick;
    int sub;
    c = noise_cmd(FUNC_TICK);
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      c.func = FUNC_TICK;
    end else if (pick < 70) begin
      c.func = FUNC_WRITE;
      sub = $urandom_range(0, 19);
      if (sub == 0) c.hold = 16'($urandom);
      else if (sub < 4) c.hold = 16'($urandom_range(0, 12));
      else c.hold = 16'($urandom_range(0, 3));
    end else if (pick < 96) begin
      c.func = FUNC_START;
      sub = $urandom_range(0, 9);
      if (sub == 0) c.length = 5'd0;
      else if (sub == 1) c.length = 5'($urandom_range(0, 31));
      else c.length = 5'($urandom_range(1, 6));
      sub = $urandom_range(0, 9);
      if (sub < 4) c.repeats = 17'($urandom_range(0, 3));
      else if (sub < 6) c.repeats = REPEAT_FOREVER;
      else if (sub == 6) c.repeats = {1'b1, 16'($urandom)};
      else if (sub == 7) c.repeats = 17'($urandom);
      else c.repeats = '0;
    end else begin
      c.func = FUNC_NONE;
    end
    return c;
  endfunction

  task automatic send(input led_cmd_t c);
    int gap;
    gap = draw_gap(req_burst);
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid         <= 1'b1;
    req.func          <= c.func;
    req.step_index    <= c.index;
    req.step_kind     <= c.kind;
    req.step_color    <= c.color;
    req.step_hold_ms  <= c.hold;
    req.seq_length    <= c.length;
    req.extra_repeats <= c.repeats;
    req.final_color   <= c.final_color;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // transaction monitors
  always @(posedge clk) begin
    if (!rst && req.valid && req.ready) begin
      seen_cmd.func = req.func;
      seen_cmd.index = req.step_index;
      seen_cmd.kind = req.step_kind;
      seen_cmd.color = req.step_color;
      seen_cmd.hold = req.step_hold_ms;
      seen_cmd.length = req.seq_length;
      seen_cmd.repeats = req.extra_repeats;
      seen_cmd.final_color = req.final_color;
      sb.predict_item(seen_cmd);
    end
    if (!rst && rsp.valid && rsp.ready)
      sb.check_result(rsp.led_color, rsp.finished, rsp.last);
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin : rsp_side
    int gap;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      gap = draw_gap(rsp_burst);
      if (rsp_long_hold) begin
        gap = LONG_HOLD;
        rsp_long_hold = 0;
      end
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
    end
  end

  initial begin : stimulus
    led_cmd_t c;
    int sent;
    sb = new();
    req_burst = 0;
    rsp_burst = 0;
    rsp_long_hold = 0;
    idle_cycles = 0;
    rst               <= 1'b1;
    req.valid         <= 1'b0;
    req.func          <= FUNC_TICK;
    req.step_index    <= '0;
    req.step_kind     <= KIND_SET;
    req.step_color    <= '0;
    req.step_hold_ms  <= '0;
    req.seq_length    <= '0;
    req.extra_repeats <= '0;
    req.final_color   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // idle tick, dropped func, empty start
    send(noise_cmd(FUNC_TICK));
    c = write_cmd(4'hf, KIND_HOLD, '1, '1);
    c.length = '1;
    c.repeats = '1;
    c.final_color = '1;
    c.func = FUNC_NONE;
    send(c);
    send(start_cmd(5'd0, 17'sd0, 24'hffffff));

    // fill the whole table before any walk
    send(write_cmd(4'd0, KIND_SET, 24'hffffff, 16'hffff));
    send(write_cmd(4'd1, KIND_SET, 24'h000000, 16'h0000));
    send(write_cmd(4'd2, KIND_SET, 24'ha5a5a5, 16'h0001));
    send(write_cmd(4'd3, KIND_SET, 24'h5a5a5a, 16'h8000));
    send(write_cmd(4'd4, KIND_HOLD, 24'h000000, 16'd2));
    send(write_cmd(4'd5, KIND_HOLD, 24'hffffff, 16'd0));
    for (int i = 6; i < 15; i++)
      send(write_cmd(4'(i), KIND_SET, 24'(i * 24'h111111), 16'($urandom)));
    send(write_cmd(4'd15, KIND_HOLD, 24'h000000, 16'hffff));

    // walk cap over wrapping passes, then continue on tick
    send(start_cmd(5'd4, 17'sd10, 24'h00ff00));
    send(noise_cmd(FUNC_TICK));
    // restart while running, hold, zero hold, finish
    send(start_cmd(5'd7, 17'sd0, 24'h123456));
    send(noise_cmd(FUNC_TICK));
    send(noise_cmd(FUNC_TICK));
    // forever repeats, write while running
    send(start_cmd(5'd2, REPEAT_FOREVER, 24'h0f0f0f));
    send(write_cmd(4'd0, KIND_SET, 24'hc3c3c3, 16'd7));
    send(noise_cmd(FUNC_TICK));
    // length above the table saturates
    send(start_cmd(5'd31, 17'sd1, 24'hfedcba));
    wait_drained();

    sent = 0;
    while (sent < ITEMS) begin
      c = random_cmd();
      if (c.func != FUNC_NONE) begin
        sent++;
        if (sent == 150) begin
          rsp_long_hold = 1;
          req_burst = 60;
        end
        if (sent == 280) wait_drained();
      end
      send(c);
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    sb.final_check();
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
